/* rtl/edd_pkg.sv */
// Shared types, constants and saturation helper for the error diffusion dither core.
`timescale 1ns / 1ps

package edd_pkg;

   localparam int ERR_W = 14;   // stored error width
   localparam int SUM_W = 20;   // working width for value, error and shares
   localparam int CSR_W = 16;   // widest configuration register
   localparam int IMG_W_W = 11; // image_width register width
   localparam int IMG_H_W = 16; // image_height register width
   localparam int PIX_W = 8;

   localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd640;
   localparam logic [IMG_H_W-1:0] IMG_H_RESET = 16'd480;

   // register indexes on the configuration port
   localparam logic REG_IMAGE_WIDTH = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   typedef logic signed [ERR_W-1:0] err_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   localparam sum_type ERR_HI = 20'sd8191;
   localparam sum_type ERR_LO = -20'sd8192;
   localparam sum_type FULL_SCALE = 20'sd4080;
   localparam sum_type THRESHOLD = 20'sd2040;

   // one write port of an error bank
   typedef struct packed {
      logic    en;
      err_type data;
   } buf_wr_type;

   function automatic err_type sat_err(input sum_type v);
      err_type r;
      if (v > ERR_HI) begin
         r = err_type'(ERR_HI);
      end else if (v < ERR_LO) begin
         r = err_type'(ERR_LO);
      end else begin
         r = err_type'(v);
      end
      return r;
   endfunction

endpackage

/* rtl/edd_row_buf.sv */
// Next-row error buffer: even and odd column banks, one write each, registered read.
`timescale 1ns / 1ps

module edd_row_buf #(
   parameter int MAX_WIDTH = 1024,
   parameter int XW = $clog2(MAX_WIDTH)
) (
   input  logic                 clock,
   input  edd_pkg::buf_wr_type  wr_even,
   input  logic [XW-1:0]        wr_even_col,
   input  edd_pkg::buf_wr_type  wr_odd,
   input  logic [XW-1:0]        wr_odd_col,
   input  logic                 rd_en,
   input  logic [XW-1:0]        rd_col,
   output edd_pkg::err_type     rd_data
);

   localparam int BDEPTH = (MAX_WIDTH + 1) / 2;
   localparam int BW = (XW > 1) ? XW - 1 : 1;

   edd_pkg::err_type even_mem [BDEPTH];
   edd_pkg::err_type odd_mem [BDEPTH];
   edd_pkg::err_type even_q_ff;
   edd_pkg::err_type odd_q_ff;
   logic             sel_odd_ff;

   logic [BW-1:0] even_wa;
   logic [BW-1:0] odd_wa;
   logic [BW-1:0] ra;

   // drop the parity bit to get the bank address
   assign even_wa = BW'(wr_even_col >> 1);
   assign odd_wa = BW'(wr_odd_col >> 1);
   assign ra = BW'(rd_col >> 1);

   always_ff @(posedge clock) begin
      if (wr_even.en) begin
         even_mem[even_wa] <= wr_even.data;
      end
      if (wr_odd.en) begin
         odd_mem[odd_wa] <= wr_odd.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         even_q_ff <= even_mem[ra];
         odd_q_ff <= odd_mem[ra];
         sel_odd_ff <= rd_col[0];
      end
   end

   assign rd_data = sel_odd_ff ? odd_q_ff : even_q_ff;

endmodule

/* rtl/error_diffusion_dither_core.sv */
// Top level of the Floyd-Steinberg error diffusion dither core.
`timescale 1ns / 1ps

//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+----------------------------------------
//  req     | in  | req_tvalid / req_tready | req_tdata[7:0] = pixel_luma
//  rsp     | out | rsp_tvalid / rsp_tready | tdata[0] dot, tlast row_end, tuser frame_end
//  csr     | in  | csr_we (always taken)   | csr_index, csr_wdata[15:0]
//
//  One pixel per clock sustained while rsp_tready stays high, set by the single diffusion pass
//  and by the two-bank error buffer, which takes both writes of a row end in the same cycle.
//  A req beat passes the input stage, then the result register, before rsp valid.
//  Reset is synchronous and active high; it clears position, carries and valids, then
//  zeroes the error buffer two columns a cycle with req_tready low until it is done.
//  A stalled rsp holds its beat while one more pixel waits in the input stage.

module error_diffusion_dither_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   // slave side
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] pixel_luma
   // master side
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [0] dot, [7:1] zero
   output logic                       rsp_tlast,   // row_end
   output logic                       rsp_tuser,   // [0] frame_end
   // configuration
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [edd_pkg::CSR_W-1:0]  csr_wdata
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int CW = (XW + 1 > edd_pkg::IMG_W_W) ? XW + 1 : edd_pkg::IMG_W_W;
   localparam int HW = edd_pkg::IMG_H_W;

   // ---------------------------------------------------------------- configuration
   logic [edd_pkg::IMG_W_W-1:0] width_ff;
   logic [HW-1:0]               height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= edd_pkg::IMG_W_RESET;
         height_ff <= edd_pkg::IMG_H_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            edd_pkg::REG_IMAGE_WIDTH: width_ff <= csr_wdata[edd_pkg::IMG_W_W-1:0];
            edd_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata[HW-1:0];
         endcase
      end
   end

   // last column and last row index, with out-of-range widths and heights clamped
   logic [CW-1:0] width_cw;
   logic [CW-1:0] col_last;
   logic [HW-1:0] row_last;

   assign width_cw = CW'(width_ff);

   always_comb begin
      if (width_ff == '0) begin
         col_last = '0;
      end else if (width_cw > CW'(MAX_WIDTH)) begin
         col_last = CW'(MAX_WIDTH - 1);
      end else begin
         col_last = width_cw - CW'(1);
      end
      row_last = (height_ff == '0) ? '0 : height_ff - HW'(1);
   end

   // ---------------------------------------------------------------- buffer clearing
   // After reset, zero one even and one odd column per cycle; hold off req meanwhile.
   logic          clr_active_ff;
   logic [XW-1:0] clr_col_ff;
   logic          clr_done;

   assign clr_done = CW'(clr_col_ff) >= CW'(MAX_WIDTH - 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_col_ff <= '0;
      end else if (clr_active_ff) begin
         if (clr_done) begin
            clr_active_ff <= 1'b0;
         end
         clr_col_ff <= clr_col_ff + XW'(2);
      end
   end

   // ---------------------------------------------------------------- handshake
   logic s1_valid_ff;
   logic out_valid_ff;
   logic fire;    // input stage diffuses into the result register
   logic accept;  // req beat taken

   assign fire = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !clr_active_ff && (!s1_valid_ff || fire);
   assign accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------- position counters
   logic [XW-1:0] col_ff;
   logic [HW-1:0] row_ff;
   logic          n_last_col;
   logic          n_last_row;

   assign n_last_col = CW'(col_ff) >= col_last;
   assign n_last_row = row_ff >= row_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (n_last_col) begin
            col_ff <= '0;
            row_ff <= n_last_row ? '0 : row_ff + HW'(1);
         end else begin
            col_ff <= col_ff + XW'(1);
         end
      end
   end

   // ---------------------------------------------------------------- input stage
   logic [7:0]        s1_pix_ff;
   logic [XW-1:0]     s1_col_ff;
   logic              s1_last_col_ff;
   logic              s1_last_row_ff;
   logic              s1_first_row_ff;
   logic              s1_fwd_ff;
   edd_pkg::err_type  s1_fwd_data_ff;

   logic              fwd_in;
   edd_pkg::err_type  fwd_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff <= req_tdata;
         s1_col_ff <= col_ff;
         s1_last_col_ff <= n_last_col;
         s1_last_row_ff <= n_last_row;
         s1_first_row_ff <= (row_ff == '0);
         s1_fwd_ff <= fwd_in;
         s1_fwd_data_ff <= fwd_data_in;
      end
   end

   // ---------------------------------------------------------------- diffusion pass
   edd_pkg::err_type right_carry_ff;
   edd_pkg::err_type below_left_ff;   // pending sum for the row below, column x-1
   edd_pkg::err_type below_ff;        // pending sum for the row below, column x
   edd_pkg::err_type buf_rd;
   edd_pkg::err_type above;
   edd_pkg::err_type mid;
   edd_pkg::err_type left_wr;
   edd_pkg::sum_type value;
   edd_pkg::sum_type err;
   edd_pkg::sum_type share7;
   edd_pkg::sum_type share5;
   edd_pkg::sum_type share3;
   edd_pkg::sum_type share1;
   logic             dot;
   logic             wr_left_en;   // write column x-1
   logic             wr_here_en;   // write column x at the row end

   always_comb begin
      above = s1_fwd_ff ? s1_fwd_data_ff : buf_rd;
      if (s1_first_row_ff) begin
         above = '0;
      end
      value = edd_pkg::sum_type'({s1_pix_ff, 4'b0000})
            + edd_pkg::sum_type'(right_carry_ff)
            + edd_pkg::sum_type'(above);
      dot = value > edd_pkg::THRESHOLD;
      err = dot ? value - edd_pkg::FULL_SCALE : value;
      // floor shares by arithmetic shift
      share7 = (err * edd_pkg::sum_type'(7)) >>> 4;
      share5 = (err * edd_pkg::sum_type'(5)) >>> 4;
      share3 = (err * edd_pkg::sum_type'(3)) >>> 4;
      share1 = err >>> 4;
      left_wr = edd_pkg::sat_err(edd_pkg::sum_type'(below_left_ff) + share3);
      mid = edd_pkg::sat_err(edd_pkg::sum_type'(below_ff) + share5);
      wr_left_en = fire && !s1_last_row_ff && (s1_col_ff != '0);
      wr_here_en = fire && !s1_last_row_ff && s1_last_col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_carry_ff <= '0;
         below_left_ff <= '0;
         below_ff <= '0;
      end else if (fire) begin
         right_carry_ff <= s1_last_col_ff ? '0 : edd_pkg::sat_err(share7);
         if (s1_last_row_ff || s1_last_col_ff) begin
            below_left_ff <= '0;
            below_ff <= '0;
         end else begin
            below_left_ff <= mid;
            below_ff <= edd_pkg::sat_err(share1);
         end
      end
   end

   // ---------------------------------------------------------------- error buffer
   // Columns x-1 and x differ in parity, so each lands in its own bank.
   edd_pkg::buf_wr_type wr_even;
   edd_pkg::buf_wr_type wr_odd;
   logic [XW-1:0]       left_col;
   logic [XW-1:0]       wr_even_col;
   logic [XW-1:0]       wr_odd_col;

   assign left_col = s1_col_ff - XW'(1);

   always_comb begin
      if (clr_active_ff) begin
         wr_even = '{en: 1'b1, data: '0};
         wr_even_col = clr_col_ff;
         wr_odd = '{en: 1'b1, data: '0};
         wr_odd_col = clr_col_ff | XW'(1);
      end else if (s1_col_ff[0]) begin
         wr_even = '{en: wr_left_en, data: left_wr};
         wr_even_col = left_col;
         wr_odd = '{en: wr_here_en, data: mid};
         wr_odd_col = s1_col_ff;
      end else begin
         wr_even = '{en: wr_here_en, data: mid};
         wr_even_col = s1_col_ff;
         wr_odd = '{en: wr_left_en, data: left_wr};
         wr_odd_col = left_col;
      end
   end

   // A read in the same cycle as a write to that column sees the old entry:
   // hold the written value aside and use it instead.
   always_comb begin
      fwd_in = 1'b0;
      fwd_data_in = mid;
      if (wr_here_en && (s1_col_ff == col_ff)) begin
         fwd_in = 1'b1;
         fwd_data_in = mid;
      end else if (wr_left_en && (left_col == col_ff)) begin
         fwd_in = 1'b1;
         fwd_data_in = left_wr;
      end
   end

   edd_row_buf #(
      .MAX_WIDTH (MAX_WIDTH),
      .XW        (XW)
   ) u_row_buf (
      .clock       (clock),
      .wr_even     (wr_even),
      .wr_even_col (wr_even_col),
      .wr_odd      (wr_odd),
      .wr_odd_col  (wr_odd_col),
      .rd_en       (accept),
      .rd_col      (col_ff),
      .rd_data     (buf_rd)
   );

   // ---------------------------------------------------------------- result register
   logic out_dot_ff;
   logic out_row_end_ff;
   logic out_frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_dot_ff <= dot;
         out_row_end_ff <= s1_last_col_ff;
         out_frame_end_ff <= s1_last_col_ff && s1_last_row_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {7'b0000000, out_dot_ff};
   assign rsp_tlast = out_row_end_ff;
   assign rsp_tuser = out_frame_end_ff;

endmodule

/* rtl/edd_checker.sv */
// Port-level checker for the dither core and its bind to the top level.
`timescale 1ns / 1ps

module edd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // a frame always ends on a row end
   a_frame_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("frame end without row end");

   // pad bits of the result stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:1] == 7'd0))
      else $error("result pad bits set");

   // reset leaves the core empty, with req beats held off as the error buffer starts to clear
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !req_tready))
      else $error("core not empty after reset");

   // a stalled result beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind error_diffusion_dither_core edd_checker u_edd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
